// ===== src/session_handshake_keepalive_macros.svh =====
// assertion macros shared by the session handshake keepalive rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef SESSION_HANDSHAKE_KEEPALIVE_MACROS_SVH
`define SESSION_HANDSHAKE_KEEPALIVE_MACROS_SVH
`ifndef SYNTHESIS
`define SHK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shk check failed");
`define SHK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shk check failed");
`else
`define SHK_ASSERT_NOW(lbl, ante, cons)
`define SHK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/shk_pkg.sv =====
// types and constants of the session handshake keepalive block
// no dependencies
package shk_pkg;

  localparam int COUNT_BITS = 32;
  localparam int MS_BITS    = 32;
  localparam int US_BITS    = 48;
  localparam int TMR_BITS   = (MS_BITS > 20) ? MS_BITS : 20;

  localparam logic [1:0] OP_POLL       = 2'd0;
  localparam logic [1:0] OP_DATAGRAM   = 2'd1;
  localparam logic [1:0] OP_CONNECT    = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  localparam logic [1:0] ST_DISC       = 2'd0;
  localparam logic [1:0] ST_CONNECTING = 2'd1;
  localparam logic [1:0] ST_CONNECTED  = 2'd2;
  localparam logic [1:0] ST_REFUSED    = 2'd3;

  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_NO_ANSWER = 2'd1;
  localparam logic [1:0] FLT_SILENT    = 2'd2;
  localparam logic [1:0] FLT_REFUSED   = 2'd3;

  localparam logic [1:0] MSG_HELLO_ACK = 2'd0;
  localparam logic [1:0] MSG_PONG      = 2'd1;

  localparam logic [1:0] REG_HELLO_RETRY  = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
  localparam logic [1:0] REG_PING_IVAL    = 2'd2;
  localparam logic [1:0] REG_SRV_TIMEOUT  = 2'd3;

  localparam logic [15:0] RST_HELLO_RETRY  = 16'd500;
  localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd10;
  localparam logic [15:0] RST_PING_IVAL    = 16'd1000;
  localparam logic [19:0] RST_SRV_TIMEOUT  = 20'd8000;

  typedef struct packed {
    logic [15:0] hello_retry_ms;
    logic [7:0]  max_hello_attempts;
    logic [15:0] ping_interval_ms;
    logic [19:0] server_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic [US_BITS-1:0] now_us;
    logic               from_server;
    logic               header_ok;
    logic [1:0]         msg_type;
    logic               decode_ok;
    logic               accepted;
    logic [US_BITS-1:0] echo_sent_us;
  } item_t;

  typedef struct packed {
    logic               send_hello;
    logic               send_ping;
    logic [US_BITS-1:0] ping_stamp_us;
    logic [1:0]         link_state;
    logic [1:0]         fault_code;
    logic [US_BITS-1:0] round_trip_us;
    logic [31:0]        sent_total;
    logic [31:0]        received_total;
    logic [31:0]        malformed_total;
    logic [7:0]         attempts_made;
    logic [31:0]        applied_total;
  } res_t;

endpackage

// ===== src/shk_core.sv =====
// session state, timers and counters; one item applied per enable
// depends on shk_pkg and session_handshake_keepalive_macros.svh
`include "session_handshake_keepalive_macros.svh"

module shk_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  shk_pkg::item_t item_i,
  input  shk_pkg::cfg_t  cfg_i,
  output shk_pkg::res_t  res_o
);

  logic [1:0]                    st_q, st_d;
  logic [1:0]                    fault_q, fault_d;
  logic [shk_pkg::MS_BITS-1:0]   hello_t_q, hello_t_d;
  logic [shk_pkg::MS_BITS-1:0]   ping_t_q, ping_t_d;
  logic [shk_pkg::MS_BITS-1:0]   heard_t_q, heard_t_d;
  logic [7:0]                    att_q, att_d;
  logic [shk_pkg::COUNT_BITS-1:0] sent_q, sent_d;
  logic [shk_pkg::COUNT_BITS-1:0] recv_q, recv_d;
  logic [shk_pkg::COUNT_BITS-1:0] mal_q, mal_d;
  logic [shk_pkg::COUNT_BITS-1:0] appl_q, appl_d;
  logic [shk_pkg::US_BITS-1:0]   rtt_q, rtt_d;

  logic [shk_pkg::MS_BITS-1:0]   now;
  logic [shk_pkg::TMR_BITS-1:0]  el_hello, el_ping, el_heard;
  logic                          hello, ping, live;

  assign now      = shk_pkg::MS_BITS'(item_i.now_ms);
  assign el_hello = shk_pkg::TMR_BITS'(now - hello_t_q);
  assign el_ping  = shk_pkg::TMR_BITS'(now - ping_t_q);
  assign el_heard = shk_pkg::TMR_BITS'(now - heard_t_q);

  always_comb begin
    st_d      = st_q;
    fault_d   = fault_q;
    hello_t_d = hello_t_q;
    ping_t_d  = ping_t_q;
    heard_t_d = heard_t_q;
    att_d     = att_q;
    sent_d    = sent_q;
    recv_d    = recv_q;
    mal_d     = mal_q;
    appl_d    = appl_q;
    rtt_d     = rtt_q;
    hello     = 1'b0;
    ping      = 1'b0;
    live      = 1'b0;
    case (item_i.op)
      shk_pkg::OP_CONNECT: begin
        sent_d    = '0;
        recv_d    = '0;
        mal_d     = '0;
        appl_d    = '0;
        att_d     = '0;
        rtt_d     = '0;
        fault_d   = shk_pkg::FLT_NONE;
        hello_t_d = '0;
        ping_t_d  = '0;
        heard_t_d = now;
        st_d      = shk_pkg::ST_CONNECTING;
      end
      shk_pkg::OP_DISCONNECT: begin
        if (st_q == shk_pkg::ST_CONNECTING || st_q == shk_pkg::ST_CONNECTED) begin
          st_d = shk_pkg::ST_DISC;
        end
      end
      default: begin
        // timer check first, poll and datagram alike
        if (st_q == shk_pkg::ST_CONNECTING) begin
          live = 1'b1;
          if (el_hello >= shk_pkg::TMR_BITS'(cfg_i.hello_retry_ms)) begin
            if (att_q >= cfg_i.max_hello_attempts) begin
              fault_d = shk_pkg::FLT_NO_ANSWER;
              st_d    = shk_pkg::ST_DISC;
              live    = 1'b0;
            end else begin
              hello     = 1'b1;
              att_d     = att_q + 8'd1;
              sent_d    = sent_q + shk_pkg::COUNT_BITS'(1);
              hello_t_d = now;
            end
          end
        end else if (st_q == shk_pkg::ST_CONNECTED) begin
          live = 1'b1;
          if (el_ping >= shk_pkg::TMR_BITS'(cfg_i.ping_interval_ms)) begin
            ping     = 1'b1;
            sent_d   = sent_q + shk_pkg::COUNT_BITS'(1);
            ping_t_d = now;
          end
          if (el_heard >= shk_pkg::TMR_BITS'(cfg_i.server_timeout_ms)) begin
            fault_d = shk_pkg::FLT_SILENT;
            st_d    = shk_pkg::ST_DISC;
            live    = 1'b0;
          end
        end
        if (item_i.op == shk_pkg::OP_DATAGRAM && live && item_i.from_server) begin
          recv_d    = recv_q + shk_pkg::COUNT_BITS'(1);
          heard_t_d = now;
          if (!item_i.header_ok) begin
            mal_d = mal_q + shk_pkg::COUNT_BITS'(1);
          end else if (item_i.msg_type == shk_pkg::MSG_HELLO_ACK) begin
            if (!item_i.decode_ok) begin
              mal_d = mal_q + shk_pkg::COUNT_BITS'(1);
            end else if (item_i.accepted) begin
              st_d = shk_pkg::ST_CONNECTED;
            end else begin
              fault_d = shk_pkg::FLT_REFUSED;
              st_d    = shk_pkg::ST_REFUSED;
            end
          end else if (item_i.msg_type == shk_pkg::MSG_PONG) begin
            if (!item_i.decode_ok) begin
              mal_d = mal_q + shk_pkg::COUNT_BITS'(1);
            end else begin
              rtt_d  = item_i.now_us - item_i.echo_sent_us;
              appl_d = appl_q + shk_pkg::COUNT_BITS'(1);
            end
          end else begin
            mal_d = mal_q + shk_pkg::COUNT_BITS'(1);
          end
        end
      end
    endcase
  end

  always_comb begin
    res_o.send_hello      = hello;
    res_o.send_ping       = ping;
    res_o.ping_stamp_us   = ping ? item_i.now_us : '0;
    res_o.link_state      = st_d;
    res_o.fault_code      = fault_d;
    res_o.round_trip_us   = rtt_d;
    res_o.sent_total      = 32'(sent_d);
    res_o.received_total  = 32'(recv_d);
    res_o.malformed_total = 32'(mal_d);
    res_o.attempts_made   = att_d;
    res_o.applied_total   = 32'(appl_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= shk_pkg::ST_DISC;
      fault_q   <= shk_pkg::FLT_NONE;
      hello_t_q <= '0;
      ping_t_q  <= '0;
      heard_t_q <= '0;
      att_q     <= '0;
      sent_q    <= '0;
      recv_q    <= '0;
      mal_q     <= '0;
      appl_q    <= '0;
      rtt_q     <= '0;
    end else if (fire_i) begin
      st_q      <= st_d;
      fault_q   <= fault_d;
      hello_t_q <= hello_t_d;
      ping_t_q  <= ping_t_d;
      heard_t_q <= heard_t_d;
      att_q     <= att_d;
      sent_q    <= sent_d;
      recv_q    <= recv_d;
      mal_q     <= mal_d;
      appl_q    <= appl_d;
      rtt_q     <= rtt_d;
    end
  end

  `SHK_ASSERT_NOW(a_hello_only_connecting, fire_i && hello, st_q == shk_pkg::ST_CONNECTING)
  `SHK_ASSERT_NOW(a_ping_only_connected, fire_i && ping, st_q == shk_pkg::ST_CONNECTED)
  `SHK_ASSERT_NEXT(a_connect_clears, fire_i && item_i.op == shk_pkg::OP_CONNECT,
                   st_q == shk_pkg::ST_CONNECTING && att_q == '0 && sent_q == '0)
  `SHK_ASSERT_NEXT(a_hold_when_idle, !fire_i, $stable(sent_q) && $stable(st_q))

endmodule

// ===== src/session_handshake_keepalive.sv =====
// session handshake keepalive: client session state with hello retry and ping
// result valid once the accepted word has passed the input register and then the output register
// an input register feeds shk_core, whose result lands in the output register
// throughput one word per cycle; input stalls only while a result waits unread
// asynchronous active-low reset: session disconnected, counters zero,
// configuration at its defaults, both stages empty
`include "session_handshake_keepalive_macros.svh"

module session_handshake_keepalive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] now_ms_i,
  input  logic [47:0] now_us_i,
  input  logic        from_server_i,
  input  logic        header_ok_i,
  input  logic [1:0]  msg_type_i,
  input  logic        decode_ok_i,
  input  logic        accepted_i,
  input  logic [47:0] echo_sent_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_hello_o,
  output logic        send_ping_o,
  output logic [47:0] ping_stamp_us_o,
  output logic [1:0]  link_state_o,
  output logic [1:0]  fault_code_o,
  output logic [47:0] round_trip_us_o,
  output logic [31:0] sent_total_o,
  output logic [31:0] received_total_o,
  output logic [31:0] malformed_total_o,
  output logic [7:0]  attempts_made_o,
  output logic [31:0] applied_total_o
);

  shk_pkg::cfg_t  cfg_q;
  shk_pkg::item_t item_q;
  shk_pkg::res_t  res;
  shk_pkg::res_t  out_q;
  logic           in_vld_q;
  logic           out_vld_q;
  logic           advance;
  logic           take;
  logic           cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hello_retry_ms     <= shk_pkg::RST_HELLO_RETRY;
      cfg_q.max_hello_attempts <= shk_pkg::RST_MAX_ATTEMPTS;
      cfg_q.ping_interval_ms   <= shk_pkg::RST_PING_IVAL;
      cfg_q.server_timeout_ms  <= shk_pkg::RST_SRV_TIMEOUT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        shk_pkg::REG_HELLO_RETRY:  cfg_q.hello_retry_ms     <= pwdata[15:0];
        shk_pkg::REG_MAX_ATTEMPTS: cfg_q.max_hello_attempts <= pwdata[7:0];
        shk_pkg::REG_PING_IVAL:    cfg_q.ping_interval_ms   <= pwdata[15:0];
        shk_pkg::REG_SRV_TIMEOUT:  cfg_q.server_timeout_ms  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      shk_pkg::REG_HELLO_RETRY:  prdata = 32'(cfg_q.hello_retry_ms);
      shk_pkg::REG_MAX_ATTEMPTS: prdata = 32'(cfg_q.max_hello_attempts);
      shk_pkg::REG_PING_IVAL:    prdata = 32'(cfg_q.ping_interval_ms);
      shk_pkg::REG_SRV_TIMEOUT:  prdata = 32'(cfg_q.server_timeout_ms);
      default:                   prdata = '0;
    endcase
  end

  // two-stage word path
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.op           <= op_i;
      item_q.now_ms       <= now_ms_i;
      item_q.now_us       <= now_us_i;
      item_q.from_server  <= from_server_i;
      item_q.header_ok    <= header_ok_i;
      item_q.msg_type     <= msg_type_i;
      item_q.decode_ok    <= decode_ok_i;
      item_q.accepted     <= accepted_i;
      item_q.echo_sent_us <= echo_sent_us_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  shk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o       = out_vld_q;
  assign send_hello_o      = out_q.send_hello;
  assign send_ping_o       = out_q.send_ping;
  assign ping_stamp_us_o   = out_q.ping_stamp_us;
  assign link_state_o      = out_q.link_state;
  assign fault_code_o      = out_q.fault_code;
  assign round_trip_us_o   = out_q.round_trip_us;
  assign sent_total_o      = out_q.sent_total;
  assign received_total_o  = out_q.received_total;
  assign malformed_total_o = out_q.malformed_total;
  assign attempts_made_o   = out_q.attempts_made;
  assign applied_total_o   = out_q.applied_total;

  `SHK_ASSERT_NOW(a_stall_needs_full, in_stall_o, in_vld_q && out_vld_q)
  `SHK_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_q)
  `SHK_ASSERT_NEXT(a_cfg_write_lands,
                   cfg_wr && paddr[3:2] == shk_pkg::REG_MAX_ATTEMPTS,
                   cfg_q.max_hello_attempts == $past(pwdata[7:0]))

endmodule
